// File: rtl/relative_date_parser_defines.svh
// Assertion macros shared by the relative date parser RTL.
`ifndef RELATIVE_DATE_PARSER_DEFINES_SVH
`define RELATIVE_DATE_PARSER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define RDP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define RDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rdp_pkg.sv
// Types, constants and reset state shared by the relative date parser.
package rdp_pkg;

    localparam int MAX_DIGITS = 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int MASK_W     = 3;
    localparam int NUM_W      = $clog2(10 ** MAX_DIGITS);
    localparam int ACC_W      = (NUM_W > YEAR_W) ? NUM_W : YEAR_W;

    localparam logic [7:0] CH_TERM  = 8'd0;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_YEAR  = 8'h79;
    localparam logic [7:0] CH_MONTH = 8'h6d;
    localparam logic [7:0] CH_DAY   = 8'h64;

    localparam logic [ACC_W-1:0] MONTH_MAX = ACC_W'(11);
    localparam logic [ACC_W-1:0] DAY_MAX   = ACC_W'(30);
    localparam logic [ACC_W-1:0] RADIX     = ACC_W'(10);
    localparam logic [ACC_W-1:0] YEAR_SAT  = ACC_W'((1 << YEAR_W) - 1);

    localparam logic [MASK_W-1:0] SEEN_YEAR  = 3'b001;
    localparam logic [MASK_W-1:0] SEEN_MONTH = 3'b010;
    localparam logic [MASK_W-1:0] SEEN_DAY   = 3'b100;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NUM   = 2'd1,
        PH_UNIT  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        U_YEAR  = 2'd0,
        U_MONTH = 2'd1,
        U_DAY   = 2'd2,
        U_NONE  = 2'd3
    } unit_t;

    typedef struct packed {
        phase_t              phase;
        logic [ACC_W-1:0]    accum;
        logic [CNT_W-1:0]    digit_count;
        unit_t               unit_pos;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [MASK_W-1:0]   seen;
        logic                failed;
    } rdp_state_t;

    typedef struct packed {
        logic [MASK_W-1:0]   present;
        logic [DAY_W-1:0]    days;
        logic [MONTH_W-1:0]  months;
        logic [YEAR_W-1:0]   years;
        logic                status;
    } rdp_result_t;

    localparam rdp_state_t STATE_RESET = '{
        phase:       PH_START,
        accum:       '0,
        digit_count: '0,
        unit_pos:    U_YEAR,
        year:        '0,
        month:       '0,
        day:         '0,
        seen:        '0,
        failed:      1'b0
    };

endpackage

// File: rtl/rdp_step.sv
// Next-state and result logic for one character of the relative date parser.
module rdp_step (
    input  rdp_pkg::rdp_state_t  state_i,
    input  logic [7:0]           ch_i,
    output rdp_pkg::rdp_state_t  state_o,
    output rdp_pkg::rdp_result_t result_o,
    output logic                 term_o
);
    import rdp_pkg::*;

    logic             is_digit;
    logic             is_ws;
    logic [ACC_W-1:0] digit_val;
    logic [ACC_W-1:0] accum_mul;
    unit_t            unit;
    logic             bad;

    assign is_digit  = ch_i inside {[CH_ZERO:CH_NINE]};
    assign is_ws     = (ch_i inside {[CH_TAB:CH_CR]}) || (ch_i == CH_SPACE);
    assign digit_val = ACC_W'(ch_i - CH_ZERO);
    assign accum_mul = ACC_W'(state_i.accum * RADIX);
    assign term_o    = (ch_i == CH_TERM);
    assign bad       = state_i.failed || (state_i.phase != PH_UNIT);

    always_comb begin
        case (ch_i)
            CH_YEAR:  unit = U_YEAR;
            CH_MONTH: unit = U_MONTH;
            CH_DAY:   unit = U_DAY;
            default:  unit = U_NONE;
        endcase
    end

    always_comb begin
        result_o.status  = bad;
        result_o.years   = bad ? '0 : state_i.year;
        result_o.months  = bad ? '0 : state_i.month;
        result_o.days    = bad ? '0 : state_i.day;
        result_o.present = bad ? '0 : state_i.seen;
    end

    always_comb begin
        state_o = state_i;
        if (term_o) begin
            state_o = STATE_RESET;
        end else if (!state_i.failed) begin
            case (state_i.phase)
                PH_NUM: begin
                    if (is_digit) begin
                        if (state_i.digit_count >= CNT_W'(MAX_DIGITS)) begin
                            state_o.failed = 1'b1;
                        end else begin
                            state_o.accum       = accum_mul + digit_val;
                            state_o.digit_count = state_i.digit_count + CNT_W'(1);
                        end
                    end else if (unit == U_NONE || unit < state_i.unit_pos) begin
                        state_o.failed = 1'b1;
                    end else begin
                        state_o.unit_pos = unit;
                        state_o.phase    = PH_UNIT;
                        case (unit)
                            U_YEAR: begin
                                state_o.year = (state_i.accum > YEAR_SAT) ?
                                    YEAR_W'(YEAR_SAT) : YEAR_W'(state_i.accum);
                                state_o.seen = state_i.seen | SEEN_YEAR;
                            end
                            U_MONTH: begin
                                if (state_i.accum > MONTH_MAX) begin
                                    state_o.failed = 1'b1;
                                end else begin
                                    state_o.month = MONTH_W'(state_i.accum);
                                    state_o.seen  = state_i.seen | SEEN_MONTH;
                                end
                            end
                            default: begin
                                if (state_i.accum > DAY_MAX) begin
                                    state_o.failed = 1'b1;
                                end else begin
                                    state_o.day  = DAY_W'(state_i.accum);
                                    state_o.seen = state_i.seen | SEEN_DAY;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    if (is_digit) begin
                        state_o.accum       = digit_val;
                        state_o.digit_count = CNT_W'(1);
                        state_o.phase       = PH_NUM;
                    end else if (!is_ws) begin
                        state_o.failed = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/relative_date_parser.sv
// Top level of the relative date parser with stream ports and result register.
// The parser takes one character per cycle and updates its state in the same
// cycle. A zero byte ends the string and loads the single result into the
// output register, which holds it until the result item is taken; other
// characters produce no result. The input side stalls only while a result
// waits in that register and is not being taken in the same cycle, so a
// string followed by its terminator flows at one character per clock.
`include "relative_date_parser_defines.svh"

module relative_date_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status, years, months, days, present, zero fill
);
    import rdp_pkg::*;

    rdp_state_t  state_reg;
    rdp_state_t  state_next;
    rdp_result_t result_next;
    rdp_result_t result_reg;
    logic        out_valid_reg;
    logic        term;
    logic        in_acc;
    logic        out_acc;

    rdp_step u_step (
        .state_i  (state_reg),
        .ch_i     (s_axis_tdata),
        .state_o  (state_next),
        .result_o (result_next),
        .term_o   (term)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                state_reg <= state_next;
            end
            if (in_acc && term) begin
                out_valid_reg <= 1'b1;
            end else if (out_acc) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && term) begin
            result_reg <= result_next;
        end
    end

    `RDP_ASSERT_NEXT(a_term_clears, in_acc && term, out_valid_reg && state_reg == STATE_RESET, "terminator did not load a result and clear the parser")
    `RDP_ASSERT_NEXT(a_no_spurious, in_acc && !term && !out_acc, out_valid_reg == $past(out_valid_reg), "result valid changed without a terminator")
    `RDP_ASSERT_ALWAYS(a_error_zero, !(out_valid_reg && result_reg.status) || (result_reg.years == '0 && result_reg.present == '0), "error result carries nonzero fields")
    `RDP_ASSERT_ALWAYS(a_count_range, state_reg.phase != PH_NUM || (state_reg.digit_count != '0 && state_reg.digit_count <= CNT_W'(MAX_DIGITS)), "digit count out of range inside a number")
    `RDP_ASSERT_ALWAYS(a_field_range, state_reg.month <= MONTH_W'(11) && state_reg.day <= DAY_W'(30), "stored month or day out of range")

endmodule
